[design/position_frequency_matrix_macros.svh]
// Assertion helpers shared by the position frequency matrix RTL.
// Both expect signals named clk and rst_n in the including module.
`ifndef POSITION_FREQUENCY_MATRIX_MACROS_SVH
`define POSITION_FREQUENCY_MATRIX_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define PFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define PFM_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/pfm_pkg.sv]
package pfm_pkg;

    // Fixed field widths
    localparam int POS_BITS   = 10;
    localparam int BYTE_BITS  = 8;
    localparam int SLOT_BITS  = 5;
    localparam int OUT_CNT_BITS = 8;
    localparam int LETTER_BITS  = 7;
    localparam int SCORE_BITS = 18;

    // Slot layout: letters A..Z, then one gap slot
    localparam int NUM_SLOTS = 27;
    localparam logic [SLOT_BITS-1:0] LETTERS  = 5'd26;
    localparam logic [SLOT_BITS-1:0] GAP_SLOT = 5'd26;
    localparam logic [SLOT_BITS-1:0] SLOT_END = 5'd27;

    // Character codes
    localparam logic [BYTE_BITS-1:0] CHAR_UC_A = 8'h41;
    localparam logic [BYTE_BITS-1:0] CHAR_UC_Z = 8'h5A;
    localparam logic [BYTE_BITS-1:0] CHAR_LC_A = 8'h61;
    localparam logic [BYTE_BITS-1:0] CHAR_LC_Z = 8'h7A;
    localparam logic [BYTE_BITS-1:0] CASE_OFFSET = 8'h20;
    localparam logic [LETTER_BITS-1:0] LETTER_A = 7'h41;

    localparam logic [SCORE_BITS-1:0] TOTAL_CEIL = 18'h3FFFF;

    // Word kinds
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Request carried from the read stage to the update stage
    typedef struct packed {
        logic                 req_type;
        logic                 in_range;
        logic [SLOT_BITS-1:0] slot;
    } pfm_req_t;

    // One result word
    typedef struct packed {
        logic [OUT_CNT_BITS-1:0] slot_count;
        logic [LETTER_BITS-1:0]  consensus_letter;
        logic [OUT_CNT_BITS-1:0] column_max;
        logic [SCORE_BITS-1:0]   max_score_total;
        logic                    saturated;
    } pfm_result_t;

    // Map a residue byte to its slot, case-insensitive
    function automatic logic [SLOT_BITS-1:0] slot_of(input logic [BYTE_BITS-1:0] b);
        logic [BYTE_BITS-1:0] u;
        u = b;
        if (b >= CHAR_LC_A && b <= CHAR_LC_Z) begin
            u = b - CASE_OFFSET;
        end
        if (u >= CHAR_UC_A && u <= CHAR_UC_Z) begin
            slot_of = SLOT_BITS'(u - CHAR_UC_A);
        end else begin
            slot_of = GAP_SLOT;
        end
    endfunction

endpackage

[design/position_frequency_matrix.sv]
// Position frequency matrix: counts residues per alignment column and keeps each
// column's consensus letter, largest letter count and the total of column maxima.
// Every column is one row of a single-port-write, registered-read memory holding
// all 27 slot counts plus consensus and maximum; each word reads its row and an
// in-range add writes it back unless the count is full. Sustained rate is one
// word per clock while out_ready is high; a result reaches out_valid through the
// update stage and output registers. While out_ready is low one more word can
// wait in the update stage before in_ready drops. A word hitting the same column
// as the one just ahead takes the just-written row from a forwarding register.
// After reset a clearing pass zeroes every row, with in_ready low throughout.
`include "position_frequency_matrix_macros.svh"

module position_frequency_matrix
    import pfm_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int COUNT_BITS  = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [POS_BITS-1:0]     position,
    input  logic [BYTE_BITS-1:0]    residue,
    input  logic [SLOT_BITS-1:0]    letter_slot,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_CNT_BITS-1:0] slot_count,
    output logic [LETTER_BITS-1:0]  consensus_letter,
    output logic [OUT_CNT_BITS-1:0] column_max,
    output logic [SCORE_BITS-1:0]   max_score_total,
    output logic                    saturated
);

    localparam int AW       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int PEXT     = POS_BITS + AW;
    localparam int CNT_W    = NUM_SLOTS * COUNT_BITS;
    localparam int ROW_W    = CNT_W + SLOT_BITS + COUNT_BITS;

    // Clearing pass
    logic          clearing_reg;
    logic [AW-1:0] clear_cnt_reg;

    // Update stage
    logic          s1_valid_reg;
    pfm_req_t      s1_req_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_adv;

    // Forwarding of the last written row
    logic             fwd_valid_reg;
    logic [AW-1:0]    fwd_addr_reg;
    logic [ROW_W-1:0] fwd_row_reg;

    logic [SCORE_BITS-1:0] score_reg;

    logic        out_valid_reg;
    pfm_result_t out_res_reg;

    logic                  accept;
    logic [PEXT-1:0]       pos_ext;
    pfm_req_t              in_req;
    logic                  item_we;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ROW_W-1:0]      ram_wdata;
    logic [ROW_W-1:0]      ram_rdata;
    logic [ROW_W-1:0]      cur_row;
    logic [ROW_W-1:0]      new_row;

    logic [NUM_SLOTS-1:0][COUNT_BITS-1:0] row_counts;
    logic [NUM_SLOTS-1:0][COUNT_BITS-1:0] new_counts;
    logic [SLOT_BITS-1:0]  new_cons;
    logic [COUNT_BITS-1:0] new_colmax;
    logic                  upd_row_we;
    logic                  upd_score_we;
    logic [SCORE_BITS-1:0] score_next;
    pfm_result_t           upd_result;

    // Handshake
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;

    // Decode the incoming word
    always_comb
    begin
        pos_ext         = PEXT'(position);
        in_req.req_type = req_type;
        in_req.in_range = pos_ext < PEXT'(MAX_COLUMNS);
        in_req.slot     = (req_type == REQ_ADD) ? slot_of(residue) : letter_slot;
    end

    // Pick the freshest copy of the row
    assign cur_row    = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_row_reg
                                                                        : ram_rdata;
    assign row_counts = cur_row[CNT_W-1:0];

    pfm_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .req         (s1_req_reg),
        .row_counts  (row_counts),
        .row_cons    (cur_row[CNT_W +: SLOT_BITS]),
        .row_colmax  (cur_row[CNT_W + SLOT_BITS +: COUNT_BITS]),
        .score_total (score_reg),
        .new_counts  (new_counts),
        .new_cons    (new_cons),
        .new_colmax  (new_colmax),
        .row_we      (upd_row_we),
        .score_we    (upd_score_we),
        .score_next  (score_next),
        .result      (upd_result)
    );

    assign new_row = {new_colmax, new_cons, new_counts};
    assign item_we = s1_adv && upd_row_we;

    // Share the write port between clearing and updates
    assign ram_we    = clearing_reg || item_we;
    assign ram_waddr = clearing_reg ? clear_cnt_reg : s1_addr_reg;
    assign ram_wdata = clearing_reg ? '0 : new_row;

    pfm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_COLUMNS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (pos_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Sweep all rows to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
        end else if (clearing_reg) begin
            if (clear_cnt_reg == AW'(MAX_COLUMNS - 1)) begin
                clearing_reg <= 1'b0;
            end else begin
                clear_cnt_reg <= clear_cnt_reg + AW'(1);
            end
        end
    end

    // Advance the update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_req_reg  <= in_req;
            s1_addr_reg <= pos_ext[AW-1:0];
        end
    end

    // Hold the last written row for the word right behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fwd_valid_reg <= 1'b0;
        end else if (item_we) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_we) begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_row_reg  <= new_row;
        end
    end

    // Running total of column maxima
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            score_reg <= '0;
        end else if (s1_adv && upd_score_we) begin
            score_reg <= score_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv) begin
            out_res_reg <= upd_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign slot_count       = out_res_reg.slot_count;
    assign consensus_letter = out_res_reg.consensus_letter;
    assign column_max       = out_res_reg.column_max;
    assign max_score_total  = out_res_reg.max_score_total;
    assign saturated        = out_res_reg.saturated;

    `PFM_NEVER(a_no_word_in_clear, clearing_reg && (in_ready || s1_valid_reg),
               "word taken during clearing pass")
    `PFM_NEVER(a_write_in_range, item_we && !s1_req_reg.in_range,
               "row write for out-of-range column")
    `PFM_ASSERT(a_accept_fills_s1, accept |=> s1_valid_reg,
                "accepted word lost before update stage")
    `PFM_ASSERT(a_fwd_tracks_write,
                item_we |=> (fwd_valid_reg && fwd_addr_reg == $past(s1_addr_reg)),
                "forwarding register missed a write")
    `PFM_ASSERT(a_stall_holds_out,
                (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_res_reg)),
                "stalled result changed")

endmodule

[design/pfm_ram.sv]
module pfm_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/pfm_update.sv]
module pfm_update
    import pfm_pkg::*;
#(
    parameter int COUNT_BITS = 8
)
(
    input  pfm_req_t                              req,
    input  logic [NUM_SLOTS-1:0][COUNT_BITS-1:0]  row_counts,
    input  logic [SLOT_BITS-1:0]                  row_cons,
    input  logic [COUNT_BITS-1:0]                 row_colmax,
    input  logic [SCORE_BITS-1:0]                 score_total,
    output logic [NUM_SLOTS-1:0][COUNT_BITS-1:0]  new_counts,
    output logic [SLOT_BITS-1:0]                  new_cons,
    output logic [COUNT_BITS-1:0]                 new_colmax,
    output logic                                  row_we,
    output logic                                  score_we,
    output logic [SCORE_BITS-1:0]                 score_next,
    output pfm_result_t                           result
);

    localparam int W8 = (COUNT_BITS > OUT_CNT_BITS) ? COUNT_BITS : OUT_CNT_BITS;
    localparam int SUM_BITS = ((COUNT_BITS > SCORE_BITS) ? COUNT_BITS : SCORE_BITS) + 1;

    logic                  slot_ok;
    logic [SLOT_BITS-1:0]  idx;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;
    logic                  at_ceil;
    logic                  is_add;
    logic [COUNT_BITS-1:0] delta;
    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] shown;
    logic [W8-1:0]         shown_ext;
    logic [W8-1:0]         colmax_ext;

    // Select and bump the addressed slot
    always_comb
    begin
        slot_ok = req.slot < SLOT_END;
        idx     = slot_ok ? req.slot : '0;
        cur     = slot_ok ? row_counts[idx] : '0;
        at_ceil = &cur;
        inc     = cur + COUNT_BITS'(1);
        is_add  = (req.req_type == REQ_ADD) && req.in_range;
        row_we  = is_add && !at_ceil;
    end

    // Update counts, column maximum, consensus and running total
    always_comb
    begin
        new_counts = row_counts;
        new_cons   = row_cons;
        new_colmax = row_colmax;
        delta      = '0;
        score_we   = 1'b0;
        if (row_we) begin
            new_counts[idx] = inc;
            if (req.slot < LETTERS) begin
                if (inc > row_colmax) begin
                    new_colmax = inc;
                    new_cons   = req.slot;
                    delta      = inc - row_colmax;
                    score_we   = 1'b1;
                end else if (inc == row_colmax && req.slot < row_cons) begin
                    new_cons = req.slot;
                end
            end
        end
        sum = SUM_BITS'(score_total) + SUM_BITS'(delta);
        if (sum > SUM_BITS'(TOTAL_CEIL)) begin
            score_next = TOTAL_CEIL;
        end else begin
            score_next = sum[SCORE_BITS-1:0];
        end
    end

    // Build the result word, masked to the port widths
    always_comb
    begin
        shown      = row_we ? inc : cur;
        shown_ext  = W8'(shown);
        colmax_ext = W8'(new_colmax);
        if (req.in_range) begin
            result.slot_count       = shown_ext[OUT_CNT_BITS-1:0];
            result.consensus_letter = LETTER_A + LETTER_BITS'(new_cons);
            result.column_max       = colmax_ext[OUT_CNT_BITS-1:0];
            result.max_score_total  = score_we ? score_next : score_total;
            result.saturated        = is_add && at_ceil;
        end else begin
            result.slot_count       = '0;
            result.consensus_letter = LETTER_A;
            result.column_max       = '0;
            result.max_score_total  = score_total;
            result.saturated        = 1'b0;
        end
    end

endmodule
